### rtl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg: shared types and constants for the matrix-vector multiplier
// Holds the request and status codes, the register map and the queue word.
// ----------------------------------------------------------------------------
package mvm_pkg;

   localparam int STORE_DEPTH      = 64;
   localparam int ADDR_W           = 6;
   localparam int DIM_W            = 4;
   localparam int DIMS_W           = 3;
   localparam int MAX_DIM          = 8;
   localparam int VALUE_WIDTH_DEF  = 32;
   localparam int ELEM_W           = 32;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 4;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QPTR_W           = 1;
   localparam int QCNT_W           = 2;

   localparam logic [DIMS_W-1:0] DIMS_VECTOR = 3'd1;
   localparam logic [DIMS_W-1:0] DIMS_MATRIX = 3'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_A_DIMS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_A_ROWS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_A_COLS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_B_DIMS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_B_ROWS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_B_COLS = 3'd5;

   typedef enum logic [1:0] {
      REQ_LOAD_A  = 2'd0,
      REQ_LOAD_B  = 2'd1,
      REQ_COMPUTE = 2'd2,
      REQ_NONE    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_MISMATCH    = 2'd1,
      STATUS_UNSUPPORTED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_MUL    = 2'd2,
      OP_ERROR  = 2'd3
   } op_kind_type;

   // One word of the queue between the front and the back.
   typedef struct packed {
      op_kind_type              kind;
      logic [ADDR_W-1:0]        addr;
      logic [ELEM_W-1:0]        value;
      status_type               status;
      logic [DIM_W-1:0]         rows;
      logic [DIM_W-1:0]         cols;
      logic [DIM_W-1:0]         inner;
   } op_type;

   function automatic logic size_ok(input logic [DIM_W-1:0] n);
      size_ok = (n != '0) && (n <= DIM_W'(MAX_DIM));
   endfunction

endpackage

### rtl/mvm_ram.sv
// ----------------------------------------------------------------------------
// mvm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mvm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mvm_front.sv
// ----------------------------------------------------------------------------
// mvm_front: shape registers and request classification
// Turns each request into a load, a multiply job or an error word.
// ----------------------------------------------------------------------------
module mvm_front #(
   parameter int VALUE_WIDTH = mvm_pkg::VALUE_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [mvm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mvm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_type,
   input  logic [mvm_pkg::ADDR_W-1:0]         req_elem_index,
   input  logic signed [mvm_pkg::ELEM_W-1:0]  req_elem_value,
   input  logic                               req_elem_is_number,
   output logic                               op_valid,
   input  logic                               op_ready,
   output mvm_pkg::op_type                    op
);
   import mvm_pkg::*;

   localparam int SAT_W = (VALUE_WIDTH < ELEM_W) ? VALUE_WIDTH : ELEM_W;

   logic [DIMS_W-1:0] a_dims_ff, b_dims_ff;
   logic [DIM_W-1:0]  a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   logic signed [SAT_W-1:0] low_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_dims_ff <= DIMS_MATRIX;
         a_rows_ff <= DIM_W'(1);
         a_cols_ff <= DIM_W'(1);
         b_dims_ff <= DIMS_MATRIX;
         b_rows_ff <= DIM_W'(1);
         b_cols_ff <= DIM_W'(1);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_A_DIMS: a_dims_ff <= csr_wdata[DIMS_W-1:0];
            CSR_A_ROWS: a_rows_ff <= csr_wdata;
            CSR_A_COLS: a_cols_ff <= csr_wdata;
            CSR_B_DIMS: b_dims_ff <= csr_wdata[DIMS_W-1:0];
            CSR_B_ROWS: b_rows_ff <= csr_wdata;
            CSR_B_COLS: b_cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign low_value = req_elem_value[SAT_W-1:0];

   // Every shape maps onto one loop nest: rows x cols results of inner terms.
   always_comb begin
      op        = '0;
      op.addr   = req_elem_index;
      op.value  = req_elem_is_number ? ELEM_W'(low_value) : '0;
      op.status = STATUS_OK;
      case (req_kind_type'(req_type))
         REQ_LOAD_A: op.kind = OP_LOAD_A;
         REQ_LOAD_B: op.kind = OP_LOAD_B;
         REQ_COMPUTE: begin
            op.kind = OP_ERROR;
            op.status = STATUS_UNSUPPORTED;
            if (a_dims_ff == DIMS_MATRIX && b_dims_ff == DIMS_MATRIX) begin
               if (size_ok(a_rows_ff) && size_ok(a_cols_ff) &&
                   size_ok(b_rows_ff) && size_ok(b_cols_ff)) begin
                  op.status = STATUS_MISMATCH;
                  if (a_cols_ff == b_rows_ff) begin
                     op.kind = OP_MUL;
                     op.status = STATUS_OK;
                  end
               end
               op.rows = a_rows_ff;
               op.cols = b_cols_ff;
               op.inner = a_cols_ff;
            end else if (a_dims_ff == DIMS_VECTOR && b_dims_ff == DIMS_VECTOR) begin
               if (size_ok(a_rows_ff) && size_ok(b_rows_ff)) begin
                  op.status = STATUS_MISMATCH;
                  if (a_rows_ff == b_rows_ff) begin
                     op.kind = OP_MUL;
                     op.status = STATUS_OK;
                  end
               end
               op.rows = DIM_W'(1);
               op.cols = DIM_W'(1);
               op.inner = a_rows_ff;
            end else if (a_dims_ff == DIMS_VECTOR && b_dims_ff == DIMS_MATRIX) begin
               if (size_ok(a_rows_ff) && size_ok(b_rows_ff) && size_ok(b_cols_ff)) begin
                  op.status = STATUS_MISMATCH;
                  if (a_rows_ff == b_rows_ff) begin
                     op.kind = OP_MUL;
                     op.status = STATUS_OK;
                  end
               end
               op.rows = DIM_W'(1);
               op.cols = b_cols_ff;
               op.inner = a_rows_ff;
            end else if (a_dims_ff == DIMS_MATRIX && b_dims_ff == DIMS_VECTOR) begin
               if (size_ok(a_rows_ff) && size_ok(a_cols_ff) && size_ok(b_rows_ff)) begin
                  op.status = STATUS_MISMATCH;
                  if (a_cols_ff == b_rows_ff) begin
                     op.kind = OP_MUL;
                     op.status = STATUS_OK;
                  end
               end
               op.rows = a_rows_ff;
               op.cols = DIM_W'(1);
               op.inner = a_cols_ff;
            end
         end
         default: op.kind = OP_ERROR;
      endcase
   end

   // Unknown requests are taken and dropped.
   assign op_valid  = req_valid && (req_kind_type'(req_type) != REQ_NONE);
   assign req_ready = op_ready;

endmodule

### rtl/mvm_queue.sv
// ----------------------------------------------------------------------------
// mvm_queue: two-entry queue between the front and the back
// Lets the front keep accepting while the back is busy with a job.
// ----------------------------------------------------------------------------
module mvm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  mvm_pkg::op_type  push_op,
   output logic             pop_valid,
   input  logic             pop_ready,
   output mvm_pkg::op_type  pop_op
);
   import mvm_pkg::*;

   op_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

### rtl/mvm_back.sv
// ----------------------------------------------------------------------------
// mvm_back: operand stores and multiply-accumulate sequencer
// Performs loads and walks each product through a pipelined MAC.
// ----------------------------------------------------------------------------
module mvm_back #(
   parameter int VALUE_WIDTH = mvm_pkg::VALUE_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               op_valid,
   output logic                               op_ready,
   input  mvm_pkg::op_type                    op,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mvm_pkg::ADDR_W-1:0]         rsp_out_index,
   output logic signed [mvm_pkg::ELEM_W-1:0]  rsp_out_value,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_last
);
   import mvm_pkg::*;

   localparam int SAT_W  = (VALUE_WIDTH < ELEM_W) ? VALUE_WIDTH : ELEM_W;
   localparam int PROD_W = 2 * SAT_W;
   localparam int ACC_W  = PROD_W + 4;
   localparam int RND_W  = ACC_W - 16;
   localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
   localparam logic signed [RND_W-1:0] SAT_MIN = RND_W'(-(64'sd1 <<< (SAT_W - 1)));

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_WAIT  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [DIM_W-1:0]  rows_ff, rows_in, cols_ff, cols_in, inner_ff, inner_in;
   logic [DIM_W-1:0]  r_ff, r_in, c_ff, c_in, i_ff, i_in;
   logic [ADDR_W-1:0] a_base_ff, a_base_in, b_addr_ff, b_addr_in, res_idx_ff, res_idx_in;

   logic s1_valid_ff, s1_first_ff, s1_last_ff;
   logic s2_valid_ff, s2_first_ff, s2_last_ff;
   logic s3_valid_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]        rsp_index_ff, rsp_index_in;
   logic signed [ELEM_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic out_free, issue, first_issue, last_issue, final_res, load_a, load_b;
   logic [SAT_W-1:0] a_rd, b_rd;
   logic signed [RND_W-1:0] rnd;
   logic signed [SAT_W-1:0] sat_val;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign first_issue = (i_ff == '0);
   assign last_issue  = (i_ff == inner_ff - DIM_W'(1));
   assign final_res   = (r_ff == rows_ff - DIM_W'(1)) && (c_ff == cols_ff - DIM_W'(1));
   assign issue       = (state_ff == ST_ISSUE) && (!first_issue || out_free);

   always_comb begin
      op_ready = 1'b0;
      if (state_ff == ST_IDLE) begin
         op_ready = (op.kind == OP_ERROR) ? out_free : 1'b1;
      end
   end

   assign load_a = op_valid && op_ready && (op.kind == OP_LOAD_A);
   assign load_b = op_valid && op_ready && (op.kind == OP_LOAD_B);

   mvm_ram #(.WIDTH(SAT_W), .DEPTH(STORE_DEPTH)) u_a_store (
      .clock   (clock),
      .wr_en   (load_a),
      .wr_addr (op.addr),
      .wr_data (op.value[SAT_W-1:0]),
      .rd_en   (issue),
      .rd_addr (a_base_ff + ADDR_W'(i_ff)),
      .rd_data (a_rd)
   );

   mvm_ram #(.WIDTH(SAT_W), .DEPTH(STORE_DEPTH)) u_b_store (
      .clock   (clock),
      .wr_en   (load_b),
      .wr_addr (op.addr),
      .wr_data (op.value[SAT_W-1:0]),
      .rd_en   (issue),
      .rd_addr (b_addr_ff),
      .rd_data (b_rd)
   );

   // Loop nest sequencer: one product term read per cycle; a result's first read waits for a free output.
   always_comb begin
      state_in   = state_ff;
      rows_in    = rows_ff;
      cols_in    = cols_ff;
      inner_in   = inner_ff;
      r_in       = r_ff;
      c_in       = c_ff;
      i_in       = i_ff;
      a_base_in  = a_base_ff;
      b_addr_in  = b_addr_ff;
      res_idx_in = res_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (op_valid && op.kind == OP_MUL) begin
               rows_in    = op.rows;
               cols_in    = op.cols;
               inner_in   = op.inner;
               r_in       = '0;
               c_in       = '0;
               i_in       = '0;
               a_base_in  = '0;
               b_addr_in  = '0;
               res_idx_in = '0;
               state_in   = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (issue) begin
               if (last_issue) begin
                  i_in     = '0;
                  state_in = ST_WAIT;
               end else begin
                  i_in      = i_ff + DIM_W'(1);
                  b_addr_in = b_addr_ff + ADDR_W'(cols_ff);
               end
            end
         end
         ST_WAIT: begin
            if (s3_valid_ff) begin
               if (final_res) begin
                  state_in = ST_IDLE;
               end else begin
                  res_idx_in = res_idx_ff + ADDR_W'(1);
                  state_in   = ST_ISSUE;
                  if (c_ff == cols_ff - DIM_W'(1)) begin
                     c_in      = '0;
                     r_in      = r_ff + DIM_W'(1);
                     a_base_in = a_base_ff + ADDR_W'(inner_ff);
                     b_addr_in = '0;
                  end else begin
                     c_in      = c_ff + DIM_W'(1);
                     b_addr_in = ADDR_W'(c_ff) + ADDR_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      acc_in = (s2_first_ff ? ACC_W'(0) : acc_ff) + ACC_W'(prod_ff);
      rnd    = RND_W'((acc_ff + ACC_W'(32768)) >>> 16);
      if (rnd > SAT_MAX) begin
         sat_val = SAT_MAX[SAT_W-1:0];
      end else if (rnd < SAT_MIN) begin
         sat_val = SAT_MIN[SAT_W-1:0];
      end else begin
         sat_val = rnd[SAT_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (s3_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_index_in  = res_idx_ff;
         rsp_value_in  = ELEM_W'(sat_val);
         rsp_status_in = STATUS_OK;
         rsp_last_in   = final_res;
      end else if (op_valid && op_ready && op.kind == OP_ERROR) begin
         rsp_valid_in  = 1'b1;
         rsp_index_in  = '0;
         rsp_value_in  = '0;
         rsp_status_in = op.status;
         rsp_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff && s2_last_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rows_ff       <= rows_in;
      cols_ff       <= cols_in;
      inner_ff      <= inner_in;
      r_ff          <= r_in;
      c_ff          <= c_in;
      i_ff          <= i_in;
      a_base_ff     <= a_base_in;
      b_addr_ff     <= b_addr_in;
      res_idx_ff    <= res_idx_in;
      s1_first_ff   <= first_issue;
      s1_last_ff    <= last_issue;
      s2_first_ff   <= s1_first_ff;
      s2_last_ff    <= s1_last_ff;
      prod_ff       <= PROD_W'($signed(a_rd)) * PROD_W'($signed(b_rd));
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTH
   a_s3_in_wait: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> state_ff == ST_WAIT)
      else $error("finished sum outside the wait state");
   a_s3_out_empty: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> !rsp_valid_ff)
      else $error("finished sum would overwrite a pending result");
   a_s3_no_reads: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> !s1_valid_ff && !issue)
      else $error("operand read in flight when a sum completes");
`endif

endmodule

### rtl/matrix_vector_multiply_top.sv
// A load is written to its store once the back takes it from the queue; loads
// stream at one word per cycle while the back is idle. Each product result takes
// one operand pair read per cycle, then multiply, accumulate and round/saturate
// stages. A stalled result holds the next result's reads. Reset clears control
// state and the shape registers; stores are kept.
// ----------------------------------------------------------------------------
// matrix_vector_multiply_top: Q16.16 matrix and vector multiplier
// Loads two operand stores word by word and emits product elements in order.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_top #(
   parameter int VALUE_WIDTH = mvm_pkg::VALUE_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Shape register write port.
   input  logic                               csr_write_en,
   input  logic [mvm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mvm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // Request channel.
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_type,
   input  logic [mvm_pkg::ADDR_W-1:0]         req_elem_index,
   input  logic signed [mvm_pkg::ELEM_W-1:0]  req_elem_value,
   input  logic                               req_elem_is_number,
   // Result channel.
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mvm_pkg::ADDR_W-1:0]         rsp_out_index,
   output logic signed [mvm_pkg::ELEM_W-1:0]  rsp_out_value,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_last
);
   import mvm_pkg::*;

   // The front decodes each request word against the shape registers. Loads,
   // multiply jobs and error words then pass through a short queue so the
   // front keeps taking words while the back works through a product.
   logic   front_valid, front_ready, back_valid, back_ready;
   op_type front_op, back_op;

   mvm_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_elem_index     (req_elem_index),
      .req_elem_value     (req_elem_value),
      .req_elem_is_number (req_elem_is_number),
      .op_valid           (front_valid),
      .op_ready           (front_ready),
      .op                 (front_op)
   );

   mvm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_op    (front_op),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_op     (back_op)
   );

   // The back owns both operand stores; every job is a loop nest of
   // rows x cols results, each a sum of inner products.
   mvm_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .op_valid      (back_valid),
      .op_ready      (back_ready),
      .op            (back_op),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_index (rsp_out_index),
      .rsp_out_value (rsp_out_value),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule

### sim/mvm_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mvm_result_checker: scoreboard for the matrix-vector multiplier
// Mirrors the shape registers and both operand stores, predicts every product
// word of each compute request and compares the result channel against it.
// ----------------------------------------------------------------------------
module mvm_result_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [mvm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mvm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [1:0]                           req_type,
   input  logic [mvm_pkg::ADDR_W-1:0]           req_elem_index,
   input  logic signed [mvm_pkg::ELEM_W-1:0]    req_elem_value,
   input  logic                                 req_elem_is_number,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [mvm_pkg::ADDR_W-1:0]           rsp_out_index,
   input  logic signed [mvm_pkg::ELEM_W-1:0]    rsp_out_value,
   input  logic [1:0]                           rsp_status,
   input  logic                                 rsp_last,
   output int                                   pending,
   output int                                   error_count,
   output int                                   product_count
);
   import mvm_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0]        idx;
      logic signed [ELEM_W-1:0] value;
      logic [1:0]               status;
      logic                     last;
   } product_word_type;

   localparam logic signed [79:0] SAT_HI = 80'sd2147483647;
   localparam logic signed [79:0] SAT_LO = -80'sd2147483648;

   product_word_type         expected_products[$];
   logic signed [ELEM_W-1:0] a_mirror[STORE_DEPTH];
   logic signed [ELEM_W-1:0] b_mirror[STORE_DEPTH];
   logic [DIMS_W-1:0]        a_dims, b_dims;
   logic [DIM_W-1:0]         a_rows, a_cols, b_rows, b_cols;

   // Exact sum of products, rounded half up to Q16.16, then saturated.
   function automatic logic signed [31:0] rounded_dot(int a0, int astep, int b0, int bstep,
                                                      int len);
      logic signed [79:0] acc;
      longint             prod;
      acc = '0;
      for (int i = 0; i < len; i++) begin
         prod = longint'(a_mirror[(a0 + i * astep) & 63]) *
                longint'(b_mirror[(b0 + i * bstep) & 63]);
         acc += prod;
      end
      acc = (acc + 80'sd32768) >>> 16;
      if (acc > SAT_HI) return 32'sh7fffffff;
      if (acc < SAT_LO) return 32'sh80000000;
      return acc[31:0];
   endfunction

   function automatic logic dim_fine(logic [DIM_W-1:0] n);
      return n >= 1 && n <= MAX_DIM;
   endfunction

   function automatic void push_word(int idx, logic signed [31:0] value,
                                     status_type st, logic last);
      product_word_type w;
      w.idx = idx[ADDR_W-1:0];
      w.value = value;
      w.status = st;
      w.last = last;
      expected_products.push_back(w);
   endfunction

   // Works out every word that one compute request produces.
   task automatic predict_product();
      int ar, ac, br, bc;
      ar = a_rows;
      ac = a_cols;
      br = b_rows;
      bc = b_cols;
      if (a_dims == DIMS_MATRIX && b_dims == DIMS_MATRIX) begin
         if (!dim_fine(a_rows) || !dim_fine(a_cols) || !dim_fine(b_rows) || !dim_fine(b_cols))
            push_word(0, 0, STATUS_UNSUPPORTED, 1'b1);
         else if (ac != br)
            push_word(0, 0, STATUS_MISMATCH, 1'b1);
         else
            for (int r = 0; r < ar; r++)
               for (int c = 0; c < bc; c++)
                  push_word(r * bc + c, rounded_dot(r * ac, 1, c, bc, ac), STATUS_OK,
                            r == ar - 1 && c == bc - 1);
      end else if (a_dims == DIMS_VECTOR && b_dims == DIMS_VECTOR) begin
         if (!dim_fine(a_rows) || !dim_fine(b_rows))
            push_word(0, 0, STATUS_UNSUPPORTED, 1'b1);
         else if (ar != br)
            push_word(0, 0, STATUS_MISMATCH, 1'b1);
         else
            push_word(0, rounded_dot(0, 1, 0, 1, ar), STATUS_OK, 1'b1);
      end else if (a_dims == DIMS_VECTOR && b_dims == DIMS_MATRIX) begin
         if (!dim_fine(a_rows) || !dim_fine(b_rows) || !dim_fine(b_cols))
            push_word(0, 0, STATUS_UNSUPPORTED, 1'b1);
         else if (ar != br)
            push_word(0, 0, STATUS_MISMATCH, 1'b1);
         else
            for (int c = 0; c < bc; c++)
               push_word(c, rounded_dot(0, 1, c, bc, ar), STATUS_OK, c == bc - 1);
      end else if (a_dims == DIMS_MATRIX && b_dims == DIMS_VECTOR) begin
         if (!dim_fine(a_rows) || !dim_fine(a_cols) || !dim_fine(b_rows))
            push_word(0, 0, STATUS_UNSUPPORTED, 1'b1);
         else if (ac != br)
            push_word(0, 0, STATUS_MISMATCH, 1'b1);
         else
            for (int r = 0; r < ar; r++)
               push_word(r, rounded_dot(r * ac, 1, 0, 1, ac), STATUS_OK, r == ar - 1);
      end else begin
         push_word(0, 0, STATUS_UNSUPPORTED, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      product_word_type want;
      if (reset) begin
         a_dims <= DIMS_MATRIX;
         b_dims <= DIMS_MATRIX;
         a_rows <= 1;
         a_cols <= 1;
         b_rows <= 1;
         b_cols <= 1;
         expected_products.delete();
         error_count <= 0;
         product_count <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_A_DIMS: a_dims <= csr_wdata[DIMS_W-1:0];
               CSR_A_ROWS: a_rows <= csr_wdata;
               CSR_A_COLS: a_cols <= csr_wdata;
               CSR_B_DIMS: b_dims <= csr_wdata[DIMS_W-1:0];
               CSR_B_ROWS: b_rows <= csr_wdata;
               CSR_B_COLS: b_cols <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_type)
               REQ_LOAD_A:
                  a_mirror[req_elem_index] = req_elem_is_number ? req_elem_value : '0;
               REQ_LOAD_B:
                  b_mirror[req_elem_index] = req_elem_is_number ? req_elem_value : '0;
               REQ_COMPUTE: predict_product();
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            product_count <= product_count + 1;
            if (expected_products.size() == 0) begin
               $display("%0t: unexpected word: index %0d value %h status %0d last %0b",
                        $time, rsp_out_index, rsp_out_value, rsp_status, rsp_last);
               error_count <= error_count + 1;
            end else begin
               want = expected_products.pop_front();
               if (want.idx !== rsp_out_index || want.value !== rsp_out_value ||
                   want.status !== rsp_status || want.last !== rsp_last) begin
                  $display("%0t: mismatch: expected index %0d value %h status %0d last %0b",
                           $time, want.idx, want.value, want.status, want.last);
                  $display("%0t:           actual   index %0d value %h status %0d last %0b",
                           $time, rsp_out_index, rsp_out_value, rsp_status, rsp_last);
                  error_count <= error_count + 1;
               end
            end
         end
      end
      pending = expected_products.size();
   end

endmodule

### sim/tb_matrix_vector_multiply_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_vector_multiply_top: testbench for the matrix-vector multiplier
// Fills both operand stores, runs directed shape and arithmetic cases, then a
// random mix of loads and products over many shapes with random idling on both
// channels. A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_matrix_vector_multiply_top;
   import mvm_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 350;

   logic                      clock;
   logic                      reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;
   logic                      req_valid;
   logic                      req_ready;
   logic [1:0]                req_type;
   logic [ADDR_W-1:0]         req_elem_index;
   logic signed [ELEM_W-1:0]  req_elem_value;
   logic                      req_elem_is_number;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [ADDR_W-1:0]         rsp_out_index;
   logic signed [ELEM_W-1:0]  rsp_out_value;
   logic [1:0]                rsp_status;
   logic                      rsp_last;

   int  pending;
   int  error_count;
   int  product_count;
   int  cycle_count;
   int  words_sent;
   int  shapes_run;
   bit  quiet;   // set for the last part of the run: no idling on either side

   matrix_vector_multiply_top u_dut (.*);

   mvm_result_checker u_checker (.*);

   // 8 ns clock.
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("matrix_vector_multiply_top verification failed");
         $finish;
      end
   end

   // The result side stalls in random bursts, with open stretches between them.
   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // Values lean toward the interesting spots: extremes, zero and near one.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($signed($urandom_range(0, 262144)) - 131072);
         3: return 32'h0000_8000;
         default: return $urandom;
      endcase
   endfunction

   // Sends one word on the request channel; may idle first. Returns after
   // the word is accepted, right after that clock edge.
   task automatic send_word(logic [1:0] kind, logic [5:0] idx, logic [31:0] value,
                            logic is_num);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_elem_index <= idx;
      req_elem_value <= value;
      req_elem_is_number <= is_num;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // Shape registers change only with the block idle: every expected word has
   // come back and the pipeline has had time to drain.
   task automatic set_shape(int ad, int ar, int ac, int bd, int br, int bc);
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= CSR_A_DIMS; csr_wdata <= CSR_DATA_W'(ad); @(posedge clock);
      csr_index <= CSR_A_ROWS; csr_wdata <= CSR_DATA_W'(ar); @(posedge clock);
      csr_index <= CSR_A_COLS; csr_wdata <= CSR_DATA_W'(ac); @(posedge clock);
      csr_index <= CSR_B_DIMS; csr_wdata <= CSR_DATA_W'(bd); @(posedge clock);
      csr_index <= CSR_B_ROWS; csr_wdata <= CSR_DATA_W'(br); @(posedge clock);
      csr_index <= CSR_B_COLS; csr_wdata <= CSR_DATA_W'(bc); @(posedge clock);
      // An index past the register list must be ignored.
      csr_index <= CSR_INDEX_W'(7); csr_wdata <= 4'hf; @(posedge clock);
      csr_write_en <= 1'b0;
      shapes_run++;
   endtask

   initial begin
      int n, kind, dim_a, dim_b, r1, c1, r2, c2;
      cycle_count = 0;
      words_sent = 0;
      shapes_run = 0;
      quiet = 1'b0;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_type = REQ_LOAD_A;
      req_elem_index = '0;
      req_elem_value = '0;
      req_elem_is_number = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every store entry is written before any product may read it.
      for (int i = 0; i < STORE_DEPTH; i++) begin
         send_word(REQ_LOAD_A, ADDR_W'(i), pick_value(), 1'b1);
         send_word(REQ_LOAD_B, ADDR_W'(i), pick_value(), 1'b1);
      end

      // Directed: reset shape is a 1x1 by 1x1 product; both saturation
      // directions, a non-numeric load and an ignored request code.
      send_word(REQ_LOAD_A, 0, 32'h7fffffff, 1'b1);
      send_word(REQ_LOAD_B, 0, 32'h7fffffff, 1'b1);
      send_word(REQ_COMPUTE, 0, 0, 1'b0);
      send_word(REQ_LOAD_B, 0, 32'h80000000, 1'b1);
      send_word(REQ_COMPUTE, 63, 32'hffffffff, 1'b1);
      send_word(REQ_LOAD_A, 0, 32'h80000000, 1'b1);
      send_word(REQ_COMPUTE, 0, 0, 1'b0);
      send_word(REQ_LOAD_B, 0, 32'h12345678, 1'b0);
      send_word(REQ_NONE, 0, 32'hffffffff, 1'b1);
      send_word(REQ_COMPUTE, 0, 0, 1'b0);
      // Rounding tie: 0.5 * 2^-16 lands exactly halfway.
      send_word(REQ_LOAD_A, 0, 32'h0000_8000, 1'b1);
      send_word(REQ_LOAD_B, 0, 32'h0000_0001, 1'b1);
      send_word(REQ_COMPUTE, 0, 0, 1'b0);
      send_word(REQ_LOAD_B, 0, 32'hffff_ffff, 1'b1);
      send_word(REQ_COMPUTE, 0, 0, 1'b0);

      // Directed shapes: each mode, mismatch, unsupported dims and sizes.
      set_shape(DIMS_VECTOR, 8, 1, DIMS_VECTOR, 8, 1);
      send_word(REQ_COMPUTE, 0, 0, 1'b0);
      set_shape(DIMS_VECTOR, 3, 0, DIMS_MATRIX, 3, 5);
      send_word(REQ_COMPUTE, 0, 0, 1'b0);
      set_shape(DIMS_MATRIX, 4, 2, DIMS_VECTOR, 2, 0);
      send_word(REQ_COMPUTE, 0, 0, 1'b0);
      set_shape(DIMS_MATRIX, 8, 8, DIMS_MATRIX, 8, 8);
      send_word(REQ_COMPUTE, 0, 0, 1'b0);
      set_shape(DIMS_MATRIX, 2, 3, DIMS_MATRIX, 4, 2);
      send_word(REQ_COMPUTE, 0, 0, 1'b0);
      set_shape(0, 2, 2, 4, 2, 2);
      send_word(REQ_COMPUTE, 0, 0, 1'b0);
      set_shape(DIMS_MATRIX, 0, 2, DIMS_MATRIX, 2, 15);
      send_word(REQ_COMPUTE, 0, 0, 1'b0);
      set_shape(DIMS_VECTOR, 9, 1, DIMS_VECTOR, 9, 1);
      send_word(REQ_COMPUTE, 0, 0, 1'b0);
      set_shape(3, 2, 2, DIMS_VECTOR, 2, 2);
      send_word(REQ_COMPUTE, 0, 0, 1'b0);

      // Random phases: mostly matching shapes with small sizes, some of the
      // largest, some broken ones; each phase streams loads and products.
      n = 0;
      while (n < RANDOM_ITEMS) begin
         if (RANDOM_ITEMS - n < 60) quiet = 1'b1;
         dim_a = $urandom_range(1, 2);
         dim_b = $urandom_range(1, 2);
         r1 = $urandom_range(1, 4);
         c1 = $urandom_range(1, 4);
         c2 = $urandom_range(1, 4);
         if ($urandom_range(0, 9) == 0) begin
            r1 = 8; c1 = 8; c2 = 8;
         end
         r2 = (dim_a == DIMS_VECTOR) ? r1 : c1;
         case ($urandom_range(0, 11))
            0: r2 = $urandom_range(1, 8);
            1: dim_a = $urandom_range(0, 4);
            2: c2 = $urandom_range(0, 15);
            3: r1 = $urandom_range(0, 15);
            default: ;
         endcase
         set_shape(dim_a, r1, c1, dim_b, r2, c2);
         repeat ($urandom_range(4, 16)) begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
               send_word(REQ_LOAD_A, ADDR_W'($urandom_range(0, 63)), pick_value(),
                         $urandom_range(0, 7) != 0);
            else if (kind < 8)
               send_word(REQ_LOAD_B, ADDR_W'($urandom_range(0, 63)), pick_value(),
                         $urandom_range(0, 7) != 0);
            else if (kind == 8)
               send_word(REQ_COMPUTE, ADDR_W'($urandom_range(0, 63)), $urandom,
                         1'($urandom_range(0, 1)));
            else
               send_word(REQ_NONE, ADDR_W'($urandom_range(0, 63)), $urandom,
                         1'($urandom_range(0, 1)));
            if (kind != 9) n++;
         end
         send_word(REQ_COMPUTE, 0, 0, 1'b0);
         n++;
      end
      req_valid <= 1'b0;

      // Drain: wait for every expected word, then a few more cycles.
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request words over %0d shape settings.", words_sent, shapes_run);
      $display("Checked %0d result words from all four multiply modes and error paths.",
               product_count);
      if (error_count == 0)
         $display("matrix_vector_multiply_top verification clean");
      else
         $display("matrix_vector_multiply_top verification failed");
      $finish;
   end

endmodule
